>>> design/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned BIT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WACK  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SACK  = 3'd6;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd500;
  localparam logic [BIT_W-1:0]  LAST_BIT   = 3'd7;

  typedef enum logic [6:0] {
    OP_IDLE  = 7'b0000001,
    OP_START = 7'b0000010,
    OP_STOP  = 7'b0000100,
    OP_WRITE = 7'b0001000,
    OP_READ  = 7'b0010000,
    OP_WACK  = 7'b0100000,
    OP_SACK  = 7'b1000000
  } op_state_t;

endpackage

>>> design/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Byte-level I2C master that sequences SCL and SDA from tick requests.
// ----------------------------------------------------------------------------
// Each input request is one timing tick and yields exactly one result showing
// the pin levels after that tick, plus busy/done, the last read byte and the
// last sampled acknowledge. One request is taken every cycle while in_stall
// is low; the next state is worked out in a single pass from the state
// registers and the request, and lands in the state and result registers
// together. The result register lets a new request in during the cycle in
// which the previous result is taken; in_stall rises only when that register
// is full and held. Every protocol wait lasts half_period requests (zero
// counts as one), so a start takes two waits, a stop three, a byte sixteen.
module i2c_master_bit_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [i2cmbe_pkg::HALF_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [i2cmbe_pkg::CMD_W-1:0]         command,
  input  logic [i2cmbe_pkg::BYTE_W-1:0]        write_data,
  input  logic                                 ack_level,
  input  logic                                 sda_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 scl_level,
  output logic                                 sda_level,
  output logic                                 sda_drive,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [i2cmbe_pkg::BYTE_W-1:0]        read_data,
  output logic                                 ack_seen
);
  import i2cmbe_pkg::*;

  logic [HALF_W-1:0]  half_period;
  op_state_t          operation, operation_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [BIT_W-1:0]   bit_count, bit_count_next;
  logic [HALF_W-1:0]  delay_count, delay_count_next;
  logic [BYTE_W-1:0]  shift_reg, shift_reg_next;
  logic [BYTE_W-1:0]  received_byte, received_byte_next;
  logic               ack_latch, ack_latch_next;
  logic               pin_scl, pin_scl_next;
  logic               pin_sda, pin_sda_next;
  logic               pin_drive, pin_drive_next;
  logic               done_next;

  logic [HALF_W-1:0]  wait_ticks;
  logic [HALF_W-1:0]  delay_dec;
  logic [PHASE_W-1:0] phase_inc;
  logic [BYTE_W-1:0]  shift_in;
  logic               accept;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = out_valid && out_stall;
  assign wait_ticks = (half_period == '0) ? HALF_W'(1) : half_period;
  assign delay_dec  = (delay_count != '0) ? delay_count - HALF_W'(1) : '0;
  assign phase_inc  = phase + PHASE_W'(1);
  assign shift_in   = {shift_reg[BYTE_W-2:0], sda_in};

  always_comb begin
    operation_next     = operation;
    phase_next         = phase;
    bit_count_next     = bit_count;
    delay_count_next   = delay_count;
    shift_reg_next     = shift_reg;
    received_byte_next = received_byte;
    ack_latch_next     = ack_latch;
    pin_scl_next       = pin_scl;
    pin_sda_next       = pin_sda;
    pin_drive_next     = pin_drive;
    done_next          = 1'b0;

    if (operation == OP_IDLE) begin
      phase_next       = '0;
      bit_count_next   = '0;
      delay_count_next = wait_ticks;
      unique case (command)
        CMD_START: begin
          operation_next = OP_START;
          pin_scl_next   = 1'b1;
          pin_drive_next = 1'b1;
          pin_sda_next   = 1'b1;
        end
        CMD_STOP: begin
          operation_next = OP_STOP;
        end
        CMD_WRITE: begin
          operation_next = OP_WRITE;
          pin_drive_next = 1'b1;
          pin_scl_next   = 1'b0;
          pin_sda_next   = write_data[BYTE_W-1];
          shift_reg_next = {write_data[BYTE_W-2:0], 1'b0};
        end
        CMD_READ: begin
          operation_next = OP_READ;
          pin_scl_next   = 1'b0;
          pin_drive_next = 1'b0;
          shift_reg_next = '0;
        end
        CMD_WACK: begin
          operation_next = OP_WACK;
        end
        CMD_SACK: begin
          operation_next = OP_SACK;
          pin_scl_next   = 1'b1;
          pin_drive_next = 1'b1;
          pin_sda_next   = ack_level;
        end
        default: begin
          delay_count_next = delay_count;
        end
      endcase
    end else if (delay_dec != '0) begin
      delay_count_next = delay_dec;
    end else begin
      phase_next       = phase_inc;
      delay_count_next = wait_ticks;
      unique case (operation)
        OP_START: begin
          if (phase_inc == PHASE_W'(1)) begin
            pin_sda_next = 1'b0;
          end else begin
            done_next = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_inc == PHASE_W'(1)) begin
            pin_drive_next = 1'b1;
            pin_sda_next   = 1'b0;
            pin_scl_next   = 1'b1;
          end else if (phase_inc == PHASE_W'(2)) begin
            pin_sda_next = 1'b1;
          end else begin
            done_next = 1'b1;
          end
        end
        OP_WACK: begin
          if (phase_inc == PHASE_W'(1)) begin
            pin_drive_next = 1'b0;
            pin_scl_next   = 1'b1;
          end else begin
            ack_latch_next = sda_in;
            pin_scl_next   = 1'b0;
            done_next      = 1'b1;
          end
        end
        OP_SACK: begin
          pin_scl_next = 1'b0;
          pin_sda_next = 1'b1;
          done_next    = 1'b1;
        end
        OP_WRITE: begin
          if (phase_inc[0]) begin
            pin_scl_next = 1'b1;
          end else begin
            bit_count_next = bit_count + BIT_W'(1);
            pin_scl_next   = 1'b0;
            if (bit_count == LAST_BIT) begin
              done_next = 1'b1;
            end else begin
              pin_sda_next   = shift_reg[BYTE_W-1];
              shift_reg_next = {shift_reg[BYTE_W-2:0], 1'b0};
            end
          end
        end
        OP_READ: begin
          if (phase_inc[0]) begin
            pin_scl_next = 1'b1;
          end else begin
            shift_reg_next = shift_in;
            bit_count_next = bit_count + BIT_W'(1);
            pin_scl_next   = 1'b0;
            if (bit_count == LAST_BIT) begin
              pin_drive_next     = 1'b1;
              pin_sda_next       = 1'b1;
              received_byte_next = shift_in;
              done_next          = 1'b1;
            end
          end
        end
        default: begin
          done_next = 1'b1;
        end
      endcase
      if (done_next) begin
        operation_next   = OP_IDLE;
        phase_next       = '0;
        bit_count_next   = '0;
        delay_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation     <= OP_IDLE;
      phase         <= '0;
      bit_count     <= '0;
      delay_count   <= '0;
      shift_reg     <= '0;
      received_byte <= '0;
      ack_latch     <= 1'b1;
      pin_scl       <= 1'b1;
      pin_sda       <= 1'b1;
      pin_drive     <= 1'b1;
    end else if (accept) begin
      operation     <= operation_next;
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      delay_count   <= delay_count_next;
      shift_reg     <= shift_reg_next;
      received_byte <= received_byte_next;
      ack_latch     <= ack_latch_next;
      pin_scl       <= pin_scl_next;
      pin_sda       <= pin_sda_next;
      pin_drive     <= pin_drive_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level <= pin_scl_next;
      sda_level <= pin_sda_next;
      sda_drive <= pin_drive_next;
      busy_res  <= (operation_next != OP_IDLE);
      done_res  <= done_next;
      read_data <= received_byte_next;
      ack_seen  <= ack_latch_next;
    end
  end

  a_busy_has_wait: assert property (@(posedge clk) disable iff (rst)
    (operation != OP_IDLE) |-> (delay_count != '0))
    else $error("busy with no wait pending");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(busy_res && done_res))
    else $error("result both busy and done");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  a_idle_counts_clear: assert property (@(posedge clk) disable iff (rst)
    (operation == OP_IDLE) |-> (phase == '0 && bit_count == '0))
    else $error("idle with stale phase or bit count");

endmodule

>>> dv/i2c_master_bit_engine_test.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_test
// Self-checking bench for the I2C master bit engine.
// ----------------------------------------------------------------------------
// Every request is one timing tick and returns one result with the pin levels,
// busy/done, the last read byte and the last sampled acknowledge. A cycle
// model in the bench replays each accepted tick and queues the expected
// result; a checker compares every returned result field by field. Directed
// tests cover the reset state, a zero half period and commands issued while
// busy. Random bus transfers then run under several short half periods, with
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_test;
  import i2cmbe_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int SILENCE_LIMIT = 4000;

  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              drive;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rdata;
    logic              ack;
  } pins_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [HALF_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = CMD_NONE;
  logic [BYTE_W-1:0]   write_data = '0;
  logic                ack_level = 1'b0;
  logic                sda_in = 1'b1;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                scl_level;
  logic                sda_level;
  logic                sda_drive;
  logic                busy_res;
  logic                done_res;
  logic [BYTE_W-1:0]   read_data;
  logic                ack_seen;

  // bus engine model state
  logic [HALF_W-1:0]   half_cfg = HALF_RESET;
  logic [CMD_W-1:0]    eng_op = CMD_NONE;
  logic [4:0]          eng_phase = '0;
  logic [3:0]          eng_bits = '0;
  logic [HALF_W-1:0]   eng_delay = '0;
  logic [BYTE_W-1:0]   eng_shift = '0;
  logic [BYTE_W-1:0]   eng_rx = '0;
  logic                eng_ack = 1'b1;
  logic                pin_scl = 1'b1;
  logic                pin_sda = 1'b1;
  logic                pin_drv = 1'b1;

  pins_t pins_due[$];
  int    mismatches = 0;
  int    ticks_sent = 0;
  int    src_quiet = 0;
  int    sink_hold = 0;
  int    silent_cycles = 0;

  i2c_master_bit_engine DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .write_data(write_data),
    .ack_level(ack_level),
    .sda_in(sda_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .scl_level(scl_level),
    .sda_level(sda_level),
    .sda_drive(sda_drive),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .ack_seen(ack_seen)
  );

  always #6 clk = ~clk;

  task automatic load_wait();
    eng_delay = (half_cfg == '0) ? HALF_W'(1) : half_cfg;
  endtask

  task automatic put_write_bit();
    pin_scl = 1'b0;
    pin_sda = eng_shift[7];
    eng_shift = {eng_shift[6:0], 1'b0};
    load_wait();
  endtask

  task automatic bus_step(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                          input logic lvl, input logic sda, output pins_t r);
    logic fin;
    fin = 1'b0;
    if (eng_op == CMD_NONE) begin
      if (cmd >= CMD_START && cmd <= CMD_SACK) begin
        eng_op = cmd;
        eng_phase = '0;
        eng_bits = '0;
        case (cmd)
          CMD_START: begin
            pin_scl = 1'b1; pin_drv = 1'b1; pin_sda = 1'b1;
            load_wait();
          end
          CMD_WRITE: begin
            pin_drv = 1'b1;
            eng_shift = data;
            put_write_bit();
          end
          CMD_READ: begin
            pin_scl = 1'b0; pin_drv = 1'b0;
            eng_shift = '0;
            load_wait();
          end
          CMD_SACK: begin
            pin_scl = 1'b1; pin_drv = 1'b1; pin_sda = lvl;
            load_wait();
          end
          default: load_wait();
        endcase
      end
    end else begin
      if (eng_delay != '0) eng_delay--;
      if (eng_delay == '0) begin
        eng_phase++;
        case (eng_op)
          CMD_START: begin
            if (eng_phase == 1) begin
              pin_sda = 1'b0;
              load_wait();
            end else fin = 1'b1;
          end
          CMD_STOP: begin
            if (eng_phase == 1) begin
              pin_drv = 1'b1; pin_sda = 1'b0; pin_scl = 1'b1;
              load_wait();
            end else if (eng_phase == 2) begin
              pin_sda = 1'b1;
              load_wait();
            end else fin = 1'b1;
          end
          CMD_WACK: begin
            if (eng_phase == 1) begin
              pin_drv = 1'b0; pin_scl = 1'b1;
              load_wait();
            end else begin
              eng_ack = sda;
              pin_scl = 1'b0;
              fin = 1'b1;
            end
          end
          CMD_SACK: begin
            pin_scl = 1'b0; pin_sda = 1'b1;
            fin = 1'b1;
          end
          CMD_WRITE: begin
            if (eng_phase[0]) begin
              pin_scl = 1'b1;
              load_wait();
            end else begin
              eng_bits++;
              if (eng_bits >= 8) begin
                pin_scl = 1'b0;
                fin = 1'b1;
              end else put_write_bit();
            end
          end
          CMD_READ: begin
            if (eng_phase[0]) begin
              pin_scl = 1'b1;
              load_wait();
            end else begin
              eng_shift = {eng_shift[6:0], sda};
              eng_bits++;
              if (eng_bits >= 8) begin
                pin_scl = 1'b0; pin_drv = 1'b1; pin_sda = 1'b1;
                eng_rx = eng_shift;
                fin = 1'b1;
              end else begin
                pin_scl = 1'b0;
                load_wait();
              end
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          eng_op = CMD_NONE;
          eng_phase = '0;
          eng_bits = '0;
        end
      end
    end
    r.scl = pin_scl;
    r.sda = pin_sda;
    r.drive = pin_drv;
    r.busy = (eng_op != CMD_NONE);
    r.done = fin;
    r.rdata = eng_rx;
    r.ack = eng_ack;
  endtask

  // one tick request; valid stays high afterwards unless a gap follows
  task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                           input logic lvl, input logic sda);
    int gap;
    int r;
    pins_t want;
    gap = 0;
    if (src_quiet > 0) src_quiet--;
    else begin
      r = $urandom_range(0, 99);
      if (r < 5) src_quiet = $urandom_range(100, 400);
      else if (r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    write_data = data;
    ack_level = lvl;
    sda_in = sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bus_step(cmd, data, lvl, sda, want);
    pins_due.push_back(want);
    ticks_sent++;
  endtask

  // issues a command and ticks until the engine is idle again
  task automatic run_cmd(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                         input logic lvl, input int sda_mode, input bit junk);
    logic [CMD_W-1:0] filler;
    logic             sda;
    sda = (sda_mode == SDA_RAND) ? 1'($urandom) : sda_mode[0];
    send_tick(cmd, data, lvl, sda);
    while (eng_op != CMD_NONE) begin
      filler = CMD_NONE;
      if (junk || $urandom_range(0, 7) == 0) filler = 3'($urandom_range(0, 7));
      sda = (sda_mode == SDA_RAND) ? 1'($urandom) : sda_mode[0];
      send_tick(filler, 8'($urandom), 1'($urandom), sda);
    end
  endtask

  task automatic set_half(input logic [HALF_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    half_cfg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic flag_field(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk) begin
    pins_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pins_due.size() == 0) flag_field("unexpected result", 0, 1);
      else begin
        want = pins_due.pop_front();
        if (scl_level !== want.scl) flag_field("scl_level", want.scl, scl_level);
        if (sda_level !== want.sda) flag_field("sda_level", want.sda, sda_level);
        if (sda_drive !== want.drive) flag_field("sda_drive", want.drive, sda_drive);
        if (busy_res !== want.busy) flag_field("busy_res", want.busy, busy_res);
        if (done_res !== want.done) flag_field("done_res", want.done, done_res);
        if (read_data !== want.rdata) flag_field("read_data", want.rdata, read_data);
        if (ack_seen !== want.ack) flag_field("ack_seen", want.ack, ack_seen);
      end
    end
  end

  always @(negedge clk) begin
    int r;
    if (sink_hold != 0) sink_hold <= sink_hold - 1;
    else begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        out_stall <= 1'b0;
        sink_hold <= $urandom_range(50, 300);
      end else if (r < 65) begin
        out_stall <= 1'b0;
        sink_hold <= $urandom_range(0, 5);
      end else if (r < 94) begin
        out_stall <= 1'b1;
        sink_hold <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        sink_hold <= $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) silent_cycles <= 0;
    else if (silent_cycles >= SILENCE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else silent_cycles <= silent_cycles + 1;
  end

  // reset pin levels and latches on idle ticks, the unused command code too
  task automatic test_reset_state();
    send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    send_tick(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
    send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // zero half period runs as one tick; field extremes and every command
  task automatic test_zero_half();
    set_half('0);
    send_tick(CMD_UNUSED, 8'hFF, 1'b1, 1'b0);
    send_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_RAND, 1'b0);
    run_cmd(CMD_WACK, 8'hFF, 1'b1, SDA_LOW, 1'b0);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_RAND, 1'b0);
    run_cmd(CMD_WACK, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_cmd(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0);
    run_cmd(CMD_SACK, 8'hFF, 1'b0, SDA_RAND, 1'b0);
    run_cmd(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_cmd(CMD_SACK, 8'h00, 1'b1, SDA_RAND, 1'b0);
    run_cmd(CMD_READ, 8'h5A, 1'b1, SDA_RAND, 1'b0);
    run_cmd(CMD_STOP, 8'hFF, 1'b1, SDA_RAND, 1'b0);
    send_tick(CMD_UNUSED, 8'h00, 1'b0, 1'b1);
  endtask

  // every tick of a busy command carries a random command code, the last one too
  task automatic test_busy_ignored();
    set_half(16'd1);
    run_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RAND, 1'b1);
    run_cmd(CMD_WRITE, 8'h5A, 1'($urandom), SDA_RAND, 1'b1);
    run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), SDA_RAND, 1'b1);
    run_cmd(CMD_READ, 8'($urandom), 1'($urandom), SDA_RAND, 1'b1);
    run_cmd(CMD_SACK, 8'($urandom), 1'b0, SDA_RAND, 1'b1);
    run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 1'b1);
  endtask

  task automatic test_random_traffic();
    int first;
    int n;
    for (int p = 0; p < 3; p++) begin
      set_half(HALF_W'($urandom_range(0, 3)));
      first = ticks_sent;
      while (ticks_sent - first < 110) begin
        if ($urandom_range(0, 99) < 80) begin
          run_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
          run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
          run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) begin
              run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
              run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
            end else begin
              run_cmd(CMD_READ, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
              run_cmd(CMD_SACK, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
            end
          end
          if ($urandom_range(0, 9) != 0)
            run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
        end else begin
          run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SDA_RAND,
                  1'($urandom_range(0, 3) == 0));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_zero_half();
    test_busy_ignored();
    test_random_traffic();
    @(negedge clk);
    in_valid = 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/i2cmbe_pkg.sv
design/i2c_master_bit_engine.sv
dv/i2c_master_bit_engine_test.sv
